[rtl/ctp_pkg.sv]
// ----------------------------------------------------------------------------
// ctp_pkg
// Shared constants and types for the conserved-to-primitive converter.
// ----------------------------------------------------------------------------
package ctp_pkg;

    localparam int CMP_W  = 66;
    localparam int ADDR_W = 4;

    typedef logic signed [CMP_W-1:0] t_cmp;

    localparam logic [1:0] REG_DIMS  = 2'd0;
    localparam logic [1:0] REG_PHASE = 2'd1;
    localparam logic [1:0] REG_TOL   = 2'd2;
    localparam logic [1:0] REG_SPARE = 2'd3;

endpackage

[rtl/ctp_delay.sv]
// ----------------------------------------------------------------------------
// ctp_delay
// Fixed-depth register line used to keep side data aligned with the dividers.
// ----------------------------------------------------------------------------
module ctp_delay #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1
) (
    input  logic             i_clk,
    input  logic [WIDTH-1:0] i_d,
    output logic [WIDTH-1:0] o_q
);

    generate
        if (DEPTH == 0) begin : g_none
            assign o_q = i_d;
        end else begin : g_line
            logic [WIDTH-1:0] r_sh [DEPTH];
            always_ff @(posedge i_clk) begin
                r_sh[0] <= i_d;
                for (int k = 1; k < DEPTH; k++) begin
                    r_sh[k] <= r_sh[k-1];
                end
            end
            assign o_q = r_sh[DEPTH-1];
        end
    endgenerate

endmodule

[rtl/ctp_div_pipe.sv]
// ----------------------------------------------------------------------------
// ctp_div_pipe
// Unsigned restoring divider, one quotient bit per register stage.
// ----------------------------------------------------------------------------
module ctp_div_pipe #(
    parameter int NUM_W = 72,
    parameter int DEN_W = 48
) (
    input  logic             i_clk,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic [NUM_W-1:0] o_quo
);

    logic [DEN_W-1:0] r_rem [NUM_W];
    logic [NUM_W-1:0] r_num [NUM_W];
    logic [DEN_W-1:0] r_den [NUM_W];

    generate
        for (genvar s = 0; s < NUM_W; s++) begin : g_stage
            logic [DEN_W-1:0] rem_in;
            logic [DEN_W-1:0] den_in;
            logic [NUM_W-1:0] num_in;
            logic [DEN_W:0]   trial;
            logic             ge;

            if (s == 0) begin : g_first
                assign rem_in = '0;
                assign num_in = i_num;
                assign den_in = i_den;
            end else begin : g_next
                assign rem_in = r_rem[s-1];
                assign num_in = r_num[s-1];
                assign den_in = r_den[s-1];
            end

            assign trial = {rem_in, num_in[NUM_W-1]};
            assign ge    = (trial >= {1'b0, den_in});

            always_ff @(posedge i_clk) begin
                r_rem[s] <= ge ? DEN_W'(trial - {1'b0, den_in}) : trial[DEN_W-1:0];
                r_num[s] <= {num_in[NUM_W-2:0], ge};
                r_den[s] <= den_in;
            end
        end
    endgenerate

    assign o_quo = r_num[NUM_W-1];

endmodule

[rtl/ctp_mul_pipe.sv]
// ----------------------------------------------------------------------------
// ctp_mul_pipe
// Unsigned two-stage multiplier: half-word partial products, then the sum.
// ----------------------------------------------------------------------------
module ctp_mul_pipe #(
    parameter int A_W = 48
) (
    input  logic             i_clk,
    input  logic [A_W-1:0]   i_a,
    input  logic [A_W-1:0]   i_b,
    output logic [2*A_W-1:0] o_p
);

    localparam int LO_W = (A_W + 1) / 2;
    localparam int HI_W = A_W - LO_W;
    localparam int P_W  = 2 * A_W;

    logic [2*LO_W-1:0]    r_ll;
    logic [LO_W+HI_W-1:0] r_lh;
    logic [LO_W+HI_W-1:0] r_hl;
    logic [2*HI_W-1:0]    r_hh;
    logic [P_W-1:0]       r_p;

    always_ff @(posedge i_clk) begin
        r_ll <= i_a[LO_W-1:0] * i_b[LO_W-1:0];
        r_lh <= i_a[LO_W-1:0] * i_b[A_W-1:LO_W];
        r_hl <= i_a[A_W-1:LO_W] * i_b[LO_W-1:0];
        r_hh <= i_a[A_W-1:LO_W] * i_b[A_W-1:LO_W];
        r_p  <= {r_hh, r_ll} + (P_W'(r_lh) << LO_W) + (P_W'(r_hl) << LO_W);
    end

    assign o_p = r_p;

endmodule

[rtl/conserved_to_primitive.sv]
// ----------------------------------------------------------------------------
// conserved_to_primitive
// Converts one cell's conserved quantities to primitive values, pipelined.
//
//  channel  | handshake              | payload
//  ---------+------------------------+-----------------------------------
//  input    | start high, busy low   | seven conserved words
//  result   | o_strobe, one cycle    | seven primitive words, valid flag
//  config   | APB, pready always high| three registers at 4*index
//
//  One beat is accepted every cycle; busy is never raised.
//  A result passes the input registers, the longer of the quotient path
//  and the kinetic path (multiplier then 2*WORD_BITS-stage divider), the
//  pressure chain and the output registers.
//  Synchronous reset clears the valid line and the registers, but sets dims to 1.
//  Results cannot be stalled and are never held back.
// ----------------------------------------------------------------------------
module conserved_to_primitive #(
    parameter int FRAC_BITS = 24,
    parameter int WORD_BITS = 48
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ctp_pkg::ADDR_W-1:0]    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    input  logic                          start,
    output logic                          busy,
    input  logic signed [WORD_BITS-1:0]   i_mass_density,
    input  logic signed [WORD_BITS-1:0]   i_gamma_density,
    input  logic signed [WORD_BITS-1:0]   i_momentum_x,
    input  logic signed [WORD_BITS-1:0]   i_momentum_y,
    input  logic signed [WORD_BITS-1:0]   i_momentum_z,
    input  logic signed [WORD_BITS-1:0]   i_total_energy,
    input  logic signed [WORD_BITS-1:0]   i_phase_density,
    output logic                          o_strobe,
    output logic signed [WORD_BITS-1:0]   o_density,
    output logic signed [WORD_BITS-1:0]   o_heat_ratio,
    output logic signed [WORD_BITS-1:0]   o_velocity_x,
    output logic signed [WORD_BITS-1:0]   o_velocity_y,
    output logic signed [WORD_BITS-1:0]   o_velocity_z,
    output logic signed [WORD_BITS-1:0]   o_pressure,
    output logic signed [WORD_BITS-1:0]   o_volume_fraction,
    output logic                          o_valid_res
);

    localparam int W    = WORD_BITS;
    localparam int F    = FRAC_BITS;
    localparam int FN_W = W + F;
    localparam int KN_W = 2 * W;
    localparam int QW   = (FN_W > KN_W) ? FN_W : KN_W;
    localparam int L_FD = FN_W;
    localparam int L_KD = 2 + KN_W;
    localparam int TA   = ((L_FD > L_KD) ? L_FD : L_KD) + 1;
    localparam int D_FD = TA - (L_FD + 1);
    localparam int D_KD = TA - (L_KD + 1);
    localparam int NV   = TA + 5;

    localparam logic [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
    localparam ctp_pkg::t_cmp CMP_MAX   = (ctp_pkg::t_cmp'(1) <<< (W-1)) - 1;
    localparam ctp_pkg::t_cmp CMP_MIN   = -(ctp_pkg::t_cmp'(1) <<< (W-1));
    localparam ctp_pkg::t_cmp CMP_ONE   = ctp_pkg::t_cmp'(1) <<< F;
    localparam ctp_pkg::t_cmp CMP_TENTH = (CMP_ONE + 5) / 10;
    localparam ctp_pkg::t_cmp CMP_HI    = CMP_ONE + CMP_TENTH;

    function automatic logic [W-1:0] mag(input logic [W-1:0] x);
        return x[W-1] ? W'(0) - x : x;
    endfunction

    // {overflow, value}: signed word from sign and magnitude, saturated
    function automatic logic [W:0] sat_mag(input logic neg, input logic [QW-1:0] q);
        logic [QW-1:0] lim;
        logic [W-1:0]  m;
        logic          ovf;
        lim = {{(QW-W){1'b0}}, WMAX} + QW'(neg);
        ovf = (q > lim);
        m   = ovf ? lim[W-1:0] : q[W-1:0];
        return {ovf, neg ? W'(0) - m : m};
    endfunction

    function automatic logic [W:0] clamp_w(input ctp_pkg::t_cmp x);
        if (x > CMP_MAX) begin
            return {1'b1, WMAX};
        end else if (x < CMP_MIN) begin
            return {1'b1, ~WMAX};
        end
        return {1'b0, x[W-1:0]};
    endfunction

    // configuration
    logic [1:0]  r_dims;
    logic        r_phase;
    logic [24:0] r_eps;
    logic        dy;
    logic        dz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dims  <= 2'd1;
            r_phase <= 1'b0;
            r_eps   <= '0;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[3:2])
                ctp_pkg::REG_DIMS:  r_dims  <= pwdata[1:0];
                ctp_pkg::REG_PHASE: r_phase <= pwdata[0];
                ctp_pkg::REG_TOL:   r_eps   <= pwdata[24:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            ctp_pkg::REG_DIMS:  prdata = {30'd0, r_dims};
            ctp_pkg::REG_PHASE: prdata = {31'd0, r_phase};
            ctp_pkg::REG_TOL:   prdata = {7'd0, r_eps};
            default:            prdata = '0;
        endcase
    end

    assign pready = 1'b1;
    assign busy   = 1'b0;
    assign dy     = r_dims[1];
    assign dz     = (r_dims == 2'd3);

    // input stage
    logic              r_vld0;
    logic [NV-1:0]     r_vld_sh;
    logic signed [W-1:0] r_rho, r_gd, r_mx, r_my, r_mz, r_e, r_ph;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld0   <= 1'b0;
            r_vld_sh <= '0;
        end else begin
            r_vld0   <= start && !busy;
            r_vld_sh <= {r_vld_sh[NV-2:0], r_vld0};
        end
    end

    always_ff @(posedge i_clk) begin
        r_rho <= i_mass_density;
        r_gd  <= i_gamma_density;
        r_mx  <= i_momentum_x;
        r_my  <= i_momentum_y;
        r_mz  <= i_momentum_z;
        r_e   <= i_total_energy;
        r_ph  <= i_phase_density;
    end

    logic [W-1:0] rho_mag;
    assign rho_mag = mag(r_rho);

    // quotient lanes: gamma, vx, vy, vz, fraction
    logic [W-1:0]     fd_num [5];
    logic [4:0]       fd_neg_in;
    logic [4:0]       fd_neg;
    logic [W:0]       r_fd_res [5];
    logic [5*(W+1)-1:0] fd_pack;
    logic [5*(W+1)-1:0] fa_pack;
    logic [W-1:0]     fa_val [5];
    logic [4:0]       fa_ovf;

    assign fd_num[0] = r_gd;
    assign fd_num[1] = r_mx;
    assign fd_num[2] = r_my;
    assign fd_num[3] = r_mz;
    assign fd_num[4] = r_ph;

    generate
        for (genvar g = 0; g < 5; g++) begin : g_fd
            logic [FN_W-1:0] quo;
            assign fd_neg_in[g] = fd_num[g][W-1] ^ r_rho[W-1];
            ctp_div_pipe #(.NUM_W(FN_W), .DEN_W(W)) u_div (
                .i_clk (i_clk),
                .i_num ({mag(fd_num[g]), {F{1'b0}}}),
                .i_den (rho_mag),
                .o_quo (quo)
            );
            always_ff @(posedge i_clk) begin
                r_fd_res[g] <= sat_mag(fd_neg[g], QW'(quo));
            end
            assign fd_pack[g*(W+1) +: W+1] = r_fd_res[g];
            assign fa_val[g] = fa_pack[g*(W+1) +: W];
            assign fa_ovf[g] = fa_pack[g*(W+1) + W];
        end
    endgenerate

    ctp_delay #(.WIDTH(5), .DEPTH(L_FD)) u_fd_sign (
        .i_clk (i_clk), .i_d (fd_neg_in), .o_q (fd_neg)
    );
    ctp_delay #(.WIDTH(5*(W+1)), .DEPTH(D_FD)) u_fd_align (
        .i_clk (i_clk), .i_d (fd_pack), .o_q (fa_pack)
    );

    // kinetic lanes: m*m / (2*rho)
    logic [W-1:0]       km_in [3];
    logic [W-1:0]       kden;
    logic               k_neg;
    logic [W:0]         r_k_res [3];
    logic [3*(W+1)-1:0] k_pack;
    logic [3*(W+1)-1:0] ka_pack;
    logic [W-1:0]       ka_val [3];
    logic [2:0]         ka_ovf;

    assign km_in[0] = mag(r_mx);
    assign km_in[1] = mag(r_my);
    assign km_in[2] = mag(r_mz);

    ctp_delay #(.WIDTH(W), .DEPTH(2)) u_kden (
        .i_clk (i_clk), .i_d (rho_mag), .o_q (kden)
    );
    ctp_delay #(.WIDTH(1), .DEPTH(L_KD)) u_k_sign (
        .i_clk (i_clk), .i_d (r_rho[W-1]), .o_q (k_neg)
    );

    generate
        for (genvar h = 0; h < 3; h++) begin : g_kin
            logic [KN_W-1:0] sq;
            logic [KN_W-1:0] quo;
            ctp_mul_pipe #(.A_W(W)) u_sq (
                .i_clk (i_clk), .i_a (km_in[h]), .i_b (km_in[h]), .o_p (sq)
            );
            ctp_div_pipe #(.NUM_W(KN_W), .DEN_W(W)) u_div (
                .i_clk (i_clk), .i_num (sq), .i_den (kden), .o_quo (quo)
            );
            always_ff @(posedge i_clk) begin
                r_k_res[h] <= sat_mag(k_neg, QW'(quo[KN_W-1:1]));
            end
            assign k_pack[h*(W+1) +: W+1] = r_k_res[h];
            assign ka_val[h] = ka_pack[h*(W+1) +: W];
            assign ka_ovf[h] = ka_pack[h*(W+1) + W];
        end
    endgenerate

    ctp_delay #(.WIDTH(3*(W+1)), .DEPTH(D_KD)) u_k_align (
        .i_clk (i_clk), .i_d (k_pack), .o_q (ka_pack)
    );

    logic signed [W-1:0] e_a;
    ctp_delay #(.WIDTH(W), .DEPTH(TA)) u_e_align (
        .i_clk (i_clk), .i_d (r_e), .o_q (e_a)
    );

    // pressure chain
    logic              ovf_a;
    logic [W:0]        c1, g1, c2, c3;
    logic signed [W-1:0] r_in1, r_in2, r_in3;
    logic signed [W-1:0] r_gm1, r_gm2, r_gm3;
    logic signed [W-1:0] r_ky1, r_kz1, r_kz2;
    logic              r_ov1, r_ov2, r_ov3;
    logic              r_pn1, r_pn2, r_po1, r_po2;
    logic [KN_W-1:0]   prod;

    assign ovf_a = fa_ovf[0] | fa_ovf[1] | ka_ovf[0]
                 | (dy & (fa_ovf[2] | ka_ovf[1]))
                 | (dz & (fa_ovf[3] | ka_ovf[2]))
                 | (r_phase & fa_ovf[4]);

    assign c1 = clamp_w(ctp_pkg::t_cmp'(e_a) - ctp_pkg::t_cmp'(signed'(ka_val[0])));
    assign g1 = clamp_w(ctp_pkg::t_cmp'(signed'(fa_val[0])) - CMP_ONE);
    assign c2 = clamp_w(ctp_pkg::t_cmp'(r_in1) - ctp_pkg::t_cmp'(r_ky1));
    assign c3 = clamp_w(ctp_pkg::t_cmp'(r_in2) - ctp_pkg::t_cmp'(r_kz2));

    always_ff @(posedge i_clk) begin
        r_in1 <= c1[W-1:0];
        r_gm1 <= g1[W-1:0];
        r_ov1 <= ovf_a | c1[W] | g1[W];
        r_ky1 <= ka_val[1];
        r_kz1 <= ka_val[2];

        r_in2 <= dy ? c2[W-1:0] : r_in1;
        r_ov2 <= r_ov1 | (dy & c2[W]);
        r_gm2 <= r_gm1;
        r_kz2 <= r_kz1;

        r_in3 <= dz ? c3[W-1:0] : r_in2;
        r_ov3 <= r_ov2 | (dz & c3[W]);
        r_gm3 <= r_gm2;

        r_pn1 <= r_in3[W-1] ^ r_gm3[W-1];
        r_pn2 <= r_pn1;
        r_po1 <= r_ov3;
        r_po2 <= r_po1;
    end

    ctp_mul_pipe #(.A_W(W)) u_pmul (
        .i_clk (i_clk), .i_a (mag(r_in3)), .i_b (mag(r_gm3)), .o_p (prod)
    );

    // output alignment
    logic [5*W-1:0] fv_pack;
    logic [5*W-1:0] fo_pack;
    logic signed [W-1:0] rho_o;

    generate
        for (genvar g = 0; g < 5; g++) begin : g_fv
            assign fv_pack[g*W +: W] = fa_val[g];
        end
    endgenerate

    ctp_delay #(.WIDTH(5*W), .DEPTH(5)) u_fv_align (
        .i_clk (i_clk), .i_d (fv_pack), .o_q (fo_pack)
    );
    ctp_delay #(.WIDTH(W), .DEPTH(NV)) u_rho_align (
        .i_clk (i_clk), .i_d (r_rho), .o_q (rho_o)
    );

    logic [W:0]          ps;
    logic                zero;
    logic                frac_bad;
    logic                neg_bad;
    ctp_pkg::t_cmp       lim;
    ctp_pkg::t_cmp       frac_c;
    logic                r_strobe;
    logic signed [W-1:0] r_o_rho, r_o_gam, r_o_vx, r_o_vy, r_o_vz, r_o_p, r_o_ph;
    logic                r_o_ok;

    assign ps       = sat_mag(r_pn2, QW'(prod[KN_W-1:F]));
    assign zero     = (rho_o == '0);
    assign lim      = -(ctp_pkg::t_cmp'(r_eps) * 100);
    assign frac_c   = ctp_pkg::t_cmp'(signed'(fo_pack[4*W +: W]));
    assign frac_bad = r_phase && ((frac_c < -CMP_TENTH) || (frac_c > CMP_HI));
    assign neg_bad  = (ctp_pkg::t_cmp'(rho_o) < lim)
                   || (ctp_pkg::t_cmp'(signed'(ps[W-1:0])) < lim);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= r_vld_sh[NV-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (zero) begin
            r_o_rho <= '0;
            r_o_gam <= '0;
            r_o_vx  <= '0;
            r_o_vy  <= '0;
            r_o_vz  <= '0;
            r_o_p   <= '0;
            r_o_ph  <= '0;
            r_o_ok  <= 1'b0;
        end else begin
            r_o_rho <= rho_o;
            r_o_gam <= fo_pack[0 +: W];
            r_o_vx  <= fo_pack[W +: W];
            r_o_vy  <= dy ? fo_pack[2*W +: W] : '0;
            r_o_vz  <= dz ? fo_pack[3*W +: W] : '0;
            r_o_p   <= ps[W-1:0];
            r_o_ph  <= r_phase ? fo_pack[4*W +: W] : '0;
            r_o_ok  <= !(frac_bad || neg_bad || r_po2 || ps[W]);
        end
    end

    assign o_strobe          = r_strobe;
    assign o_density         = r_o_rho;
    assign o_heat_ratio      = r_o_gam;
    assign o_velocity_x      = r_o_vx;
    assign o_velocity_y      = r_o_vy;
    assign o_velocity_z      = r_o_vz;
    assign o_pressure        = r_o_p;
    assign o_volume_fraction = r_o_ph;
    assign o_valid_res       = r_o_ok;

endmodule

[test/ctp_checker.sv]
// ----------------------------------------------------------------------------
// ctp_checker
// Watches the config, input and result ports of conserved_to_primitive.
// Keeps its own copy of the registers, predicts each cell's primitive
// values in wide fixed point and compares every result beat field by field.
// ----------------------------------------------------------------------------
module ctp_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    input  logic [31:0]        prdata,
    input  logic               pready,
    input  logic               start,
    input  logic               busy,
    input  logic signed [47:0] i_mass_density,
    input  logic signed [47:0] i_gamma_density,
    input  logic signed [47:0] i_momentum_x,
    input  logic signed [47:0] i_momentum_y,
    input  logic signed [47:0] i_momentum_z,
    input  logic signed [47:0] i_total_energy,
    input  logic signed [47:0] i_phase_density,
    input  logic               o_strobe,
    input  logic signed [47:0] o_density,
    input  logic signed [47:0] o_heat_ratio,
    input  logic signed [47:0] o_velocity_x,
    input  logic signed [47:0] o_velocity_y,
    input  logic signed [47:0] o_velocity_z,
    input  logic signed [47:0] o_pressure,
    input  logic signed [47:0] o_volume_fraction,
    input  logic               o_valid_res,
    output int                 o_errors,
    output int                 o_pending,
    output int                 o_results
);

    typedef logic signed [47:0]  t_word;
    typedef logic signed [129:0] t_wide;

    typedef struct {
        t_word f[7];
        logic  ok;
    } t_prim;

    localparam longint WMAX  = 64'sd140737488355327;
    localparam longint WMIN  = -64'sd140737488355328;
    localparam longint ONE   = 64'sd16777216;
    localparam longint TENTH = (ONE + 5) / 10;

    logic [1:0]  dims;
    logic        two_phase;
    logic [24:0] tol;
    bit          sat_hit;
    t_prim       prim_q[$];
    int          errors, results;

    function automatic t_word clip(t_wide v);
        if (v > WMAX) begin
            sat_hit = 1;
            return t_word'(WMAX);
        end
        if (v < WMIN) begin
            sat_hit = 1;
            return t_word'(WMIN);
        end
        return t_word'(v);
    endfunction

    function automatic t_word quot(t_word num, t_word den);
        t_wide n;
        n = t_wide'(num) <<< 24;
        return clip(n / t_wide'(den));
    endfunction

    function automatic t_word kin(t_word m, t_word rho);
        t_wide mm, r, q;
        mm = t_wide'(m) * t_wide'(m);
        r  = (rho < 0) ? -t_wide'(rho) : t_wide'(rho);
        q  = (mm / r) >>> 1;
        return clip((rho < 0) ? -q : q);
    endfunction

    function automatic t_word diff(t_word a, t_word b);
        return clip(t_wide'(a) - t_wide'(b));
    endfunction

    function automatic t_word mulq(t_word a, t_word b);
        t_wide one_w;
        one_w = t_wide'(ONE);
        return clip((t_wide'(a) * t_wide'(b)) / one_w);
    endfunction

    function automatic t_prim to_primitive(t_word vals[7]);
        t_prim  p;
        t_word  rho, inner, lim;
        p.ok = 0;
        for (int j = 0; j < 7; j++) p.f[j] = '0;
        sat_hit = 0;
        rho = vals[0];
        if (rho != 0) begin
            p.f[0] = rho;
            p.f[1] = quot(vals[1], rho);
            p.f[2] = quot(vals[2], rho);
            inner  = diff(vals[5], kin(vals[2], rho));
            if (dims > 1) begin
                p.f[3] = quot(vals[3], rho);
                inner  = diff(inner, kin(vals[3], rho));
            end
            if (dims > 2) begin
                p.f[4] = quot(vals[4], rho);
                inner  = diff(inner, kin(vals[4], rho));
            end
            p.f[5] = mulq(inner, diff(p.f[1], t_word'(ONE)));
            p.ok = 1;
            if (two_phase) begin
                p.f[6] = quot(vals[6], rho);
                if (p.f[6] < -TENTH || p.f[6] > ONE + TENTH) p.ok = 0;
            end
            lim = -t_word'(100 * longint'(tol));
            if (rho < lim || p.f[5] < lim || sat_hit) p.ok = 0;
        end
        return p;
    endfunction

    function automatic logic [31:0] reg_value(logic [1:0] idx);
        case (idx)
            ctp_pkg::REG_DIMS:  return {30'd0, dims};
            ctp_pkg::REG_PHASE: return {31'd0, two_phase};
            ctp_pkg::REG_TOL:   return {7'd0, tol};
            default:            return '0;
        endcase
    endfunction

    always @(posedge i_clk) begin
        t_word vals[7];
        t_word got[7];
        t_prim e;
        if (!i_rst_n) begin
            dims      = 2'd1;
            two_phase = 1'b0;
            tol       = '0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[3:2])
                    ctp_pkg::REG_DIMS:  dims = pwdata[1:0];
                    ctp_pkg::REG_PHASE: two_phase = pwdata[0];
                    ctp_pkg::REG_TOL:   tol = pwdata[24:0];
                    default: ;
                endcase
            end
            if (psel && penable && !pwrite && pready && paddr[3:2] <= ctp_pkg::REG_TOL &&
                prdata !== reg_value(paddr[3:2])) begin
                errors++;
                $display("%0t reg %0d read: expected %h actual %h", $time,
                         paddr[3:2], reg_value(paddr[3:2]), prdata);
            end
            if (start && !busy) begin
                vals = '{i_mass_density, i_gamma_density, i_momentum_x, i_momentum_y,
                         i_momentum_z, i_total_energy, i_phase_density};
                prim_q.push_back(to_primitive(vals));
            end
            if (o_strobe) begin
                results++;
                got = '{o_density, o_heat_ratio, o_velocity_x, o_velocity_y,
                        o_velocity_z, o_pressure, o_volume_fraction};
                if (prim_q.size() == 0) begin
                    errors++;
                    $display("%0t result beat with nothing expected", $time);
                end else begin
                    e = prim_q.pop_front();
                    for (int j = 0; j < 7; j++) begin
                        if (got[j] !== e.f[j]) begin
                            errors++;
                            $display("%0t field %0d: expected %h actual %h",
                                     $time, j, e.f[j], got[j]);
                        end
                    end
                    if (o_valid_res !== e.ok) begin
                        errors++;
                        $display("%0t valid_res: expected %b actual %b",
                                 $time, e.ok, o_valid_res);
                    end
                end
            end
        end
        o_errors  <= errors;
        o_pending <= prim_q.size();
        o_results <= results;
    end

endmodule

[test/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for conserved_to_primitive. Sets the registers over
// APB between phases, sends directed and random cells with random sender
// gaps, and leaves prediction and comparison to ctp_checker.
// ----------------------------------------------------------------------------
module tb_top;

    typedef logic signed [47:0] t_word;

    localparam longint ONE   = 64'sd16777216;
    localparam longint TENTH = (ONE + 5) / 10;
    localparam longint WMAX  = 64'sd140737488355327;
    localparam longint WMIN  = -64'sd140737488355328;
    localparam int     DRAIN = 2 * 48 + 20;
    localparam int     LIMIT = 20000;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        psel = 0, penable = 0, pwrite = 0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        start = 0;
    logic        busy;
    t_word       i_mass_density = '0, i_gamma_density = '0, i_momentum_x = '0;
    t_word       i_momentum_y = '0, i_momentum_z = '0, i_total_energy = '0;
    t_word       i_phase_density = '0;
    logic        o_strobe, o_valid_res;
    t_word       o_density, o_heat_ratio, o_velocity_x, o_velocity_y;
    t_word       o_velocity_z, o_pressure, o_volume_fraction;
    int          n_errors, n_pending, n_results;
    int          idle_cycles = 0;
    int          gap_pct = 0;
    int          sent = 0;

    always #1 i_clk = ~i_clk;

    conserved_to_primitive dut (.*);

    ctp_checker u_checker (
        .*,
        .o_errors(n_errors),
        .o_pending(n_pending),
        .o_results(n_results)
    );

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_strobe) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send(t_word vals[7]);
        start           <= 1'b1;
        i_mass_density  <= vals[0];
        i_gamma_density <= vals[1];
        i_momentum_x    <= vals[2];
        i_momentum_y    <= vals[3];
        i_momentum_z    <= vals[4];
        i_total_energy  <= vals[5];
        i_phase_density <= vals[6];
        do @(posedge i_clk); while (busy);
        sent++;
        while ($urandom_range(99) < gap_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    task automatic quiesce();
        start <= 1'b0;
        @(posedge i_clk);
        @(posedge i_clk);
        while (n_pending != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
    endtask

    task automatic apb(logic wr, logic [1:0] idx, logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_regs(logic [31:0] d, logic [31:0] ph, logic [31:0] t);
        quiesce();
        apb(1, ctp_pkg::REG_DIMS, d);
        apb(1, ctp_pkg::REG_PHASE, ph);
        apb(1, ctp_pkg::REG_TOL, t);
        apb(1, ctp_pkg::REG_SPARE, $urandom);
        for (int k = 0; k < 4; k++) apb(0, k[1:0], '0);
    endtask

    function automatic t_word rnd_word();
        logic [63:0] r;
        r = {$urandom, $urandom};
        if ($urandom_range(1)) return t_word'(r[47:0]);
        return t_word'(r[47:0]) >>> $urandom_range(0, 47);
    endfunction

    task automatic dir(longint rho, gd, mx, my, mz, e, ph);
        t_word vals[7];
        vals = '{t_word'(rho), t_word'(gd), t_word'(mx), t_word'(my),
                 t_word'(mz), t_word'(e), t_word'(ph)};
        send(vals);
    endtask

    task automatic random_cell();
        t_word  vals[7];
        longint rho, v, m, ke, pick;
        pick = $urandom_range(99);
        if (pick < 25) begin
            for (int j = 0; j < 7; j++) vals[j] = rnd_word();
            if (pick < 3) vals[0] = '0;
            else if (pick < 8) vals[0] = t_word'(longint'($urandom_range(0, 64)) - 32);
        end else begin
            rho = $urandom_range(1 << 12, 1 << 30);
            if ($urandom_range(19) == 0) rho = -rho;
            vals[0] = t_word'(rho);
            vals[1] = t_word'((rho * longint'($urandom_range(1 << 24, 3 << 24))) >>> 24);
            ke = 0;
            for (int a = 2; a < 5; a++) begin
                v  = longint'($urandom_range(0, 8 << 24)) - (4 << 24);
                m  = (rho * v) >>> 24;
                ke += (m * (v >>> 2)) >>> 23;
                vals[a] = t_word'(m);
            end
            vals[5] = t_word'(ke + ((rho * (longint'($urandom_range(0, 5 << 24)) -
                                            (1 << 24))) >>> 24));
            vals[6] = t_word'((rho * (longint'($urandom_range(0, 23488102)) -
                                      3355443)) >>> 24);
        end
        send(vals);
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        for (int k = 0; k < 3; k++) apb(0, k[1:0], '0);

        gap_pct = 13;
        repeat (200) random_cell();

        set_regs(32'd3, 32'd1, 32'd1024);
        dir(0, 0, 0, 0, 0, 0, 0);
        dir(WMAX, WMAX, WMAX, WMAX, WMAX, WMAX, WMAX);
        dir(WMIN, WMIN, WMIN, WMIN, WMIN, WMIN, WMIN);
        dir(1, 1, 1, 1, 1, 1, 1);
        dir(-1, 0, WMAX, WMIN, 1, 0, 0);
        dir(ONE, 23488102, ONE / 2, ONE / 2, ONE / 2, 4 * ONE, ONE / 2);
        dir(ONE, 23488102, 0, 0, 0, ONE, -TENTH - 1);
        dir(ONE, 23488102, 0, 0, 0, ONE, -TENTH);
        dir(ONE, 23488102, 0, 0, 0, ONE, ONE + TENTH);
        dir(ONE, 23488102, 0, 0, 0, ONE, ONE + TENTH + 1);
        dir(ONE, 23488102, ONE, ONE, ONE, 0, ONE / 2);
        dir(-102400, -143360, 0, 0, 0, 0, -51200);
        dir(-102401, -143360, 0, 0, 0, 0, -51200);
        dir(1, ONE, ONE, -ONE, ONE, ONE, 0);
        dir(WMIN, WMIN, WMIN, 0, WMAX, WMAX, WMIN);
        dir(ONE, ONE, ONE, 0, 0, 8 * ONE, ONE);
        dir(ONE, 3 * ONE, 0, 0, 0, -ONE, 0);
        dir(WMAX, 0, 0, 0, 0, WMIN, 0);
        repeat (280) random_cell();

        gap_pct = 67;
        set_regs(32'd2, 32'd0, 32'h01FF_FFFF);
        repeat (280) random_cell();
        set_regs(32'hFFFF_FFF0, 32'hFFFF_FFFF, 32'd16777216);
        repeat (280) random_cell();

        gap_pct = 0;
        set_regs(32'd3, 32'hFFFF_FFFE, 32'hFE00_0000);
        repeat (280) random_cell();
        set_regs(32'd1, 32'd1, 32'd1);
        repeat (360) random_cell();

        quiesce();
        $display("Sent %0d cells over six register settings; %0d results compared.",
                 sent, n_results);
        if (n_errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
